[src/bfa_pkg.sv]
package bfa_pkg;

    localparam int MAX_FRAMES   = 4096;
    localparam int ORDER_LEVELS = 13;
    localparam int FIDX_W       = 12;
    localparam int LINK_W       = 13;
    localparam int CNT_W        = 13;
    localparam int ORD_W        = 4;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_FRAMES);
    localparam logic [ORD_W-1:0]  TOP_MAX   = ORD_W'(ORDER_LEVELS - 1);

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_RESERVE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_NOFREE = 2'd1,
        STS_RANGE  = 2'd2,
        STS_STATE  = 2'd3
    } status_t;

    // Per-frame flags, kept together in one memory word.
    typedef struct packed {
        logic             busy;
        logic             inner;
        logic [ORD_W-1:0] order;
    } fword_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_CLR, OP_LOAD, OP_DISP, OP_SETST, OP_ASCAN, OP_ASPLIT,
        OP_FRD, OP_FCHK, OP_GRD, OP_MRG1, OP_MRG2, OP_GEND, OP_FCNT,
        OP_RRD, OP_RCHK, OP_RSPLIT, OP_ULRD, OP_ULWR, OP_AP1, OP_AP2, OP_DONE
    } op_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_A_SCAN, ST_A_SPLIT,
        ST_F_RD, ST_F_CHK, ST_G_CHK, ST_G_BUD, ST_G_MRG1, ST_G_MRG2,
        ST_G_END, ST_F_CNT, ST_R_RD, ST_R_CHK, ST_R_SPLIT,
        ST_UL_RD, ST_UL_WR, ST_AP1, ST_AP2,
        ST_FAIL_NF, ST_FAIL_RG, ST_FAIL_ST, ST_DONE
    } state_t;

    typedef struct packed {
        op_t     op;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic cfg_wr;
        logic clr_last;
        req_t req;
        logic ord_bad;
        logic range_bad;
        logic head_hit;
        logic k_top;
        logic k_eq_ord;
        logic k_zero;
        logic fr_bad;
        logic bud_ok;
        logic r_inner;
        logic h_zero;
        logic rs_bad;
        logic out_free;
    } stat_t;

    function automatic logic [ORD_W-1:0] top_of(input logic [CNT_W-1:0] c);
        logic [ORD_W-1:0] t;
        t = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (c[i]) begin
                t = ORD_W'(i);
            end
        end
        if (t > TOP_MAX) begin
            t = TOP_MAX;
        end
        return t;
    endfunction

endpackage

[src/bfa_ctrl.sv]
module bfa_ctrl
    import bfa_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t st,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ret_reg   <= ST_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd.op     = OP_NOP;
        cmd.code   = STS_OK;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.op = OP_CLR;
                if (st.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                cmd.op = OP_DISP;
                if (st.req == REQ_ALLOC) begin
                    state_next = st.ord_bad ? ST_FAIL_NF : ST_A_SCAN;
                end else if (st.range_bad) begin
                    state_next = ST_FAIL_RG;
                end else if (st.req == REQ_RESERVE) begin
                    state_next = ST_R_RD;
                end else begin
                    state_next = ST_F_RD;
                end
            end
            ST_A_SCAN: begin
                cmd.op = OP_ASCAN;
                if (st.head_hit) begin
                    ret_next   = ST_A_SPLIT;
                    state_next = ST_UL_RD;
                end else if (st.k_top) begin
                    state_next = ST_FAIL_NF;
                end
            end
            ST_A_SPLIT: begin
                cmd.op = OP_ASPLIT;
                if (st.k_eq_ord) begin
                    state_next = ST_DONE;
                end else begin
                    ret_next   = ST_A_SPLIT;
                    state_next = ST_AP1;
                end
            end
            ST_F_RD: begin
                cmd.op     = OP_FRD;
                state_next = ST_F_CHK;
            end
            ST_F_CHK: begin
                cmd.op     = OP_FCHK;
                state_next = st.fr_bad ? ST_FAIL_ST : ST_G_CHK;
            end
            ST_G_CHK: begin
                cmd.op     = OP_GRD;
                state_next = st.k_top ? ST_G_END : ST_G_BUD;
            end
            ST_G_BUD: begin
                if (st.bud_ok) begin
                    ret_next   = ST_G_MRG1;
                    state_next = ST_UL_RD;
                end else begin
                    state_next = ST_G_END;
                end
            end
            ST_G_MRG1: begin
                cmd.op     = OP_MRG1;
                state_next = ST_G_MRG2;
            end
            ST_G_MRG2: begin
                cmd.op     = OP_MRG2;
                state_next = ST_G_CHK;
            end
            ST_G_END: begin
                cmd.op     = OP_GEND;
                ret_next   = ST_F_CNT;
                state_next = ST_AP1;
            end
            ST_F_CNT: begin
                cmd.op     = OP_FCNT;
                state_next = ST_DONE;
            end
            ST_R_RD: begin
                cmd.op     = OP_RRD;
                state_next = ST_R_CHK;
            end
            ST_R_CHK: begin
                cmd.op = OP_RCHK;
                if (st.r_inner) begin
                    state_next = st.h_zero ? ST_FAIL_ST : ST_R_RD;
                end else if (st.rs_bad) begin
                    state_next = ST_FAIL_ST;
                end else begin
                    ret_next   = ST_R_SPLIT;
                    state_next = ST_UL_RD;
                end
            end
            ST_R_SPLIT: begin
                cmd.op = OP_RSPLIT;
                if (st.k_zero) begin
                    state_next = ST_DONE;
                end else begin
                    ret_next   = ST_R_SPLIT;
                    state_next = ST_AP1;
                end
            end
            ST_UL_RD: begin
                cmd.op     = OP_ULRD;
                state_next = ST_UL_WR;
            end
            ST_UL_WR: begin
                cmd.op     = OP_ULWR;
                state_next = ret_reg;
            end
            ST_AP1: begin
                cmd.op     = OP_AP1;
                state_next = ST_AP2;
            end
            ST_AP2: begin
                cmd.op     = OP_AP2;
                state_next = ret_reg;
            end
            ST_FAIL_NF: begin
                cmd.op     = OP_SETST;
                cmd.code   = STS_NOFREE;
                state_next = ST_DONE;
            end
            ST_FAIL_RG: begin
                cmd.op     = OP_SETST;
                cmd.code   = STS_RANGE;
                state_next = ST_DONE;
            end
            ST_FAIL_ST: begin
                cmd.op     = OP_SETST;
                cmd.code   = STS_STATE;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                cmd.op = OP_DONE;
                if (st.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // A zone rebuild restarts the clearing pass from any state.
        if (st.cfg_wr) begin
            state_next = ST_CLEAR;
        end
    end

endmodule

[src/bfa_dp.sv]
module bfa_dp
    import bfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output stat_t       st,
    input  logic [1:0]  s_tuser,
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata
);

    fword_t              fmem [MAX_FRAMES];
    logic [LINK_W-1:0]   lnext [MAX_FRAMES];
    logic [LINK_W-1:0]   lprev [MAX_FRAMES];

    logic [CNT_W-1:0]    cnt_reg, free_reg, busy_reg;
    logic [ORD_W-1:0]    top_reg, ord_reg, k_reg, kfree_reg;
    req_t                req_reg;
    status_t             sts_reg;
    logic [FIDX_W-1:0]   idx_reg, h_reg, f_reg, clr_reg, blk_reg;
    logic [LINK_W-1:0]   head_reg [ORDER_LEVELS];
    logic [LINK_W-1:0]   tail_reg [ORDER_LEVELS];
    logic                m_valid_reg;
    logic [39:0]         m_data_reg;

    fword_t              fm_rd;
    logic [LINK_W-1:0]   ln_rd, lp_rd;

    logic                fm_we, fm_re, ln_we, lp_we, lk_re;
    logic [FIDX_W-1:0]   fm_waddr, fm_raddr, ln_waddr, lp_waddr;
    fword_t              fm_wdata;
    logic [LINK_W-1:0]   ln_wdata, lp_wdata;

    logic                cfg_we, k_ok, out_free;
    logic [CNT_W-1:0]    cfg_val, pw_ord, pw_kfree;
    logic [LINK_W-1:0]   head_k, tail_k;
    logic [FIDX_W-1:0]   half, r_idx, bud, lo_idx, hi_idx;
    logic [CNT_W:0]      blk_end;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b,
                                                 input logic [CNT_W-1:0] lim);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, lim}) ? lim : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    assign cfg_we   = psel & penable & pwrite & ~paddr[2];
    assign prdata   = paddr[2] ? 32'd0 : {{(32-CNT_W){1'b0}}, cnt_reg};
    assign out_free = ~m_valid_reg | m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        cfg_val = pwdata[CNT_W-1:0];
        if (cfg_val == '0) begin
            cfg_val = CNT_W'(1);
        end else if (cfg_val > CNT_W'(MAX_FRAMES)) begin
            cfg_val = CNT_W'(MAX_FRAMES);
        end
    end

    assign k_ok     = (k_reg <= TOP_MAX);
    assign head_k   = k_ok ? head_reg[k_reg] : LINK_NULL;
    assign tail_k   = k_ok ? tail_reg[k_reg] : LINK_NULL;
    assign pw_ord   = CNT_W'(1) << ord_reg;
    assign pw_kfree = CNT_W'(1) << kfree_reg;
    assign half     = FIDX_W'(1) << (k_reg - ORD_W'(1));
    assign r_idx    = h_reg + half;
    assign bud      = h_reg ^ (FIDX_W'(1) << k_reg);
    assign lo_idx   = (h_reg < f_reg) ? h_reg : f_reg;
    assign hi_idx   = (h_reg < f_reg) ? f_reg : h_reg;
    assign blk_end  = {2'b00, h_reg} + ((CNT_W+1)'(1) << fm_rd.order);

    always_comb begin
        st.cfg_wr    = cfg_we;
        st.clr_last  = &clr_reg;
        st.req       = req_reg;
        st.ord_bad   = ord_reg > top_reg;
        st.range_bad = {1'b0, idx_reg} >= cnt_reg;
        st.head_hit  = ~head_k[LINK_W-1];
        st.k_top     = k_reg >= top_reg;
        st.k_eq_ord  = k_reg == ord_reg;
        st.k_zero    = k_reg == '0;
        st.fr_bad    = ~fm_rd.busy | fm_rd.inner;
        st.bud_ok    = ({1'b0, f_reg} < cnt_reg) & ~fm_rd.inner & ~fm_rd.busy &
                       (fm_rd.order == k_reg);
        st.r_inner   = fm_rd.inner;
        st.h_zero    = h_reg == '0;
        st.rs_bad    = fm_rd.busy | (fm_rd.order > top_reg) |
                       (blk_end <= {2'b00, idx_reg});
        st.out_free  = out_free;
    end

    // Memory port control.
    always_comb begin
        fm_we    = 1'b0;
        fm_waddr = h_reg;
        fm_wdata = '{busy: 1'b0, inner: 1'b0, order: k_reg};
        fm_re    = 1'b0;
        fm_raddr = h_reg;
        lk_re    = 1'b0;
        ln_we    = 1'b0;
        ln_waddr = f_reg;
        ln_wdata = LINK_NULL;
        lp_we    = 1'b0;
        lp_waddr = f_reg;
        lp_wdata = tail_k;
        case (cmd.op)
            OP_CLR: begin
                fm_we    = 1'b1;
                fm_waddr = clr_reg;
                fm_wdata = '{busy: 1'b1, inner: 1'b0, order: '0};
            end
            OP_ASPLIT: begin
                fm_we = 1'b1;
                if (k_reg == ord_reg) begin
                    fm_wdata = '{busy: 1'b1, inner: 1'b0, order: ord_reg};
                end else begin
                    fm_waddr = r_idx;
                    fm_wdata = '{busy: 1'b0, inner: 1'b0, order: k_reg - ORD_W'(1)};
                end
            end
            OP_MRG1: begin
                fm_we    = 1'b1;
                fm_waddr = hi_idx;
                fm_wdata = '{busy: 1'b0, inner: 1'b1, order: k_reg};
            end
            OP_MRG2: begin
                fm_we    = 1'b1;
                fm_waddr = lo_idx;
                fm_wdata = '{busy: 1'b0, inner: 1'b0, order: k_reg + ORD_W'(1)};
            end
            OP_GEND: begin
                fm_we = 1'b1;
            end
            OP_RSPLIT: begin
                fm_we = 1'b1;
                if (k_reg == '0) begin
                    fm_wdata = '{busy: 1'b1, inner: 1'b0, order: '0};
                end else begin
                    fm_waddr = ({1'b0, idx_reg} >= {1'b0, r_idx}) ? h_reg : r_idx;
                    fm_wdata = '{busy: 1'b0, inner: 1'b0, order: k_reg - ORD_W'(1)};
                end
            end
            OP_FRD: begin
                fm_re    = 1'b1;
                fm_raddr = idx_reg;
            end
            OP_GRD: begin
                fm_re    = 1'b1;
                fm_raddr = bud;
            end
            OP_RRD: begin
                fm_re = 1'b1;
            end
            OP_ULRD: begin
                lk_re = 1'b1;
            end
            OP_ULWR: begin
                ln_we    = ~lp_rd[LINK_W-1];
                ln_waddr = lp_rd[FIDX_W-1:0];
                ln_wdata = ln_rd;
                lp_we    = ~ln_rd[LINK_W-1];
                lp_waddr = ln_rd[FIDX_W-1:0];
                lp_wdata = lp_rd;
            end
            OP_AP1: begin
                ln_we = 1'b1;
                lp_we = 1'b1;
            end
            OP_AP2: begin
                ln_we    = ~tail_k[LINK_W-1];
                ln_waddr = tail_k[FIDX_W-1:0];
                ln_wdata = {1'b0, f_reg};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (fm_we) begin
            fmem[fm_waddr] <= fm_wdata;
        end
        if (fm_re) begin
            fm_rd <= fmem[fm_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ln_we) begin
            lnext[ln_waddr] <= ln_wdata;
        end
        if (lp_we) begin
            lprev[lp_waddr] <= lp_wdata;
        end
        if (lk_re) begin
            ln_rd <= lnext[f_reg];
            lp_rd <= lprev[f_reg];
        end
    end

    // Control state: zone shape, counts, list ends and the output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= CNT_W'(MAX_FRAMES);
            top_reg     <= top_of(CNT_W'(MAX_FRAMES));
            free_reg    <= CNT_W'(MAX_FRAMES);
            busy_reg    <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < ORDER_LEVELS; i++) begin
                head_reg[i] <= LINK_NULL;
                tail_reg[i] <= LINK_NULL;
            end
        end else if (cfg_we) begin
            cnt_reg  <= cfg_val;
            top_reg  <= top_of(cfg_val);
            free_reg <= cfg_val;
            busy_reg <= '0;
            clr_reg  <= '0;
            for (int i = 0; i < ORDER_LEVELS; i++) begin
                head_reg[i] <= LINK_NULL;
                tail_reg[i] <= LINK_NULL;
            end
        end else begin
            if (cmd.op == OP_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_CLR: begin
                    clr_reg <= clr_reg + FIDX_W'(1);
                end
                OP_ASPLIT: begin
                    if (k_reg == ord_reg) begin
                        free_reg <= sat_sub(free_reg, pw_ord);
                        busy_reg <= sat_add(busy_reg, pw_ord, cnt_reg);
                    end
                end
                OP_FCNT: begin
                    if (req_reg == REQ_FREE && kfree_reg <= top_reg) begin
                        free_reg <= sat_add(free_reg, pw_kfree, cnt_reg);
                        busy_reg <= sat_sub(busy_reg, pw_kfree);
                    end
                end
                OP_RSPLIT: begin
                    if (k_reg == '0) begin
                        free_reg <= sat_sub(free_reg, CNT_W'(1));
                    end
                end
                OP_ULWR: begin
                    if (lp_rd[LINK_W-1]) begin
                        head_reg[k_reg] <= ln_rd;
                    end
                    if (ln_rd[LINK_W-1]) begin
                        tail_reg[k_reg] <= lp_rd;
                    end
                end
                OP_AP2: begin
                    if (tail_k[LINK_W-1]) begin
                        head_reg[k_reg] <= {1'b0, f_reg};
                    end
                    tail_reg[k_reg] <= {1'b0, f_reg};
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers of the current request.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                req_reg <= req_t'(s_tuser);
                ord_reg <= s_tdata[ORD_W-1:0];
                idx_reg <= s_tdata[ORD_W+FIDX_W-1:ORD_W];
            end
            OP_DISP: begin
                sts_reg <= STS_OK;
                blk_reg <= '0;
                k_reg   <= ord_reg;
                h_reg   <= idx_reg;
            end
            OP_SETST: begin
                sts_reg <= cmd.code;
            end
            OP_ASCAN: begin
                if (~head_k[LINK_W-1]) begin
                    h_reg <= head_k[FIDX_W-1:0];
                    f_reg <= head_k[FIDX_W-1:0];
                end else begin
                    k_reg <= k_reg + ORD_W'(1);
                end
            end
            OP_ASPLIT: begin
                if (k_reg == ord_reg) begin
                    blk_reg <= h_reg;
                end else begin
                    f_reg <= r_idx;
                    k_reg <= k_reg - ORD_W'(1);
                end
            end
            OP_FCHK: begin
                h_reg     <= idx_reg;
                kfree_reg <= fm_rd.order;
                k_reg     <= (fm_rd.order > top_reg) ? top_reg : fm_rd.order;
            end
            OP_GRD: begin
                f_reg <= bud;
            end
            OP_MRG2: begin
                h_reg <= lo_idx;
                k_reg <= k_reg + ORD_W'(1);
            end
            OP_GEND: begin
                f_reg <= h_reg;
            end
            OP_RCHK: begin
                if (fm_rd.inner) begin
                    if (h_reg != '0) begin
                        h_reg <= h_reg - FIDX_W'(1);
                    end
                end else begin
                    f_reg <= h_reg;
                    k_reg <= fm_rd.order;
                end
            end
            OP_RSPLIT: begin
                if (k_reg != '0) begin
                    if ({1'b0, idx_reg} >= {1'b0, r_idx}) begin
                        f_reg <= h_reg;
                        h_reg <= r_idx;
                    end else begin
                        f_reg <= r_idx;
                    end
                    k_reg <= k_reg - ORD_W'(1);
                end
            end
            OP_DONE: begin
                if (out_free) begin
                    m_data_reg <= {busy_reg, free_reg, blk_reg, sts_reg};
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[src/buddy_frame_allocator_top.sv]
// Allocate scans the free lists upward from the requested order, then splits the block
// found down to that order; free and release merge the block with free buddies on the way
// up, then append it to a list. Reserve first walks back frame by frame to its block head.
// One request is in flight at a time; the next is taken once its result is registered.
// After reset and every frame_count write, a clearing pass over all frame words runs
// with input held.
module buddy_frame_allocator_top
    import bfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // order[3:0], frame_no[15:4]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], block_index[13:2],
                                   // free_frames[26:14], busy_frames[39:27]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cmd_t  cmd;
    stat_t st;

    assign pready = 1'b1;

    bfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    bfa_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata)
    );

endmodule

[tb/sv/testbench.sv]
module testbench
    import bfa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 50000;
    localparam int SETTLE      = 80;

    typedef struct packed {
        status_t          st;
        logic [11:0]      blk;
        logic [CNT_W-1:0] fr;
        logic [CNT_W-1:0] bz;
    } reply_t;

    typedef struct {
        bit      cfg;
        req_t    rq;
        int      o;
        int      ix;
        bit      typed;
        status_t st;
        int      blk;
        int      fr;
        int      bz;
    } step_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // order[3:0], frame_no[15:4]
    logic [1:0]  s_tuser = '0;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // status[1:0], block_index[13:2],
                                 // free_frames[26:14], busy_frames[39:27]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    buddy_frame_allocator_top i_dut (.*);

    always #5 aclk = ~aclk;

    // Shadow of the zone.
    bit         z_busy [MAX_FRAMES];
    logic [3:0] z_ord [MAX_FRAMES];
    bit         z_inner [MAX_FRAMES];
    int         z_next [MAX_FRAMES];
    int         z_prev [MAX_FRAMES];
    int         z_head [ORDER_LEVELS];
    int         z_tail [ORDER_LEVELS];
    int         z_count, z_top, z_free, z_used;

    reply_t awaited_replies[$];
    int     held_blocks[$];
    int     sender_idle, receiver_idle;
    int     mismatches, requests_sent, replies_seen, settings_used;
    int     quiet_cycles;
    bit     failed;

    function automatic void zone_build(int c);
        int k;
        if (c < 1) c = 1;
        if (c > MAX_FRAMES) c = MAX_FRAMES;
        z_count = c;
        k = 0;
        while (c > 1) begin
            c >>= 1;
            k++;
        end
        z_top = (k > ORDER_LEVELS - 1) ? ORDER_LEVELS - 1 : k;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            z_busy[i] = 1;
            z_ord[i] = '0;
            z_inner[i] = 0;
            z_next[i] = 0;
            z_prev[i] = 0;
        end
        for (int i = 0; i < ORDER_LEVELS; i++) begin
            z_head[i] = MAX_FRAMES;
            z_tail[i] = MAX_FRAMES;
        end
        z_free = z_count;
        z_used = 0;
    endfunction

    function automatic void list_put(int f, int k);
        int t;
        t = z_tail[k];
        z_next[f] = MAX_FRAMES;
        z_prev[f] = t;
        if (t < MAX_FRAMES) z_next[t] = f;
        else z_head[k] = f;
        z_tail[k] = f;
    endfunction

    function automatic void list_cut(int f, int k);
        int p, n;
        p = z_prev[f];
        n = z_next[f];
        if (p < MAX_FRAMES) z_next[p] = n;
        else z_head[k] = n;
        if (n < MAX_FRAMES) z_prev[n] = p;
        else z_tail[k] = p;
    endfunction

    function automatic int add_sat(int a, int b);
        return (a + b > z_count) ? z_count : a + b;
    endfunction

    function automatic int sub_sat(int a, int b);
        return (a > b) ? a - b : 0;
    endfunction

    // Returns a freed block to the lists, merging with free buddies on the way up.
    function automatic void merge_up(int b);
        int k, bud, h;
        forever begin
            k = z_ord[b];
            if (k > z_top) k = z_top;
            if (k < z_top) begin
                bud = ((b >> k) & 1) ? b - (1 << k) : b + (1 << k);
                if (bud < z_count && !z_inner[bud] && !z_busy[bud] && z_ord[bud] == k) begin
                    list_cut(bud, k);
                    z_inner[b] = 1;
                    z_inner[bud] = 1;
                    h = (b < bud) ? b : bud;
                    z_inner[h] = 0;
                    z_ord[h] = 4'(k + 1);
                    b = h;
                    continue;
                end
            end
            z_ord[b] = 4'(k);
            list_put(b, k);
            return;
        end
    endfunction

    function automatic int halve(int h, int k);
        int r;
        r = h + (1 << (k - 1));
        z_ord[h] = 4'(k - 1);
        z_ord[r] = 4'(k - 1);
        z_inner[r] = 0;
        return r;
    endfunction

    function automatic reply_t allocator_step(req_t rq, int o, int ix);
        reply_t res;
        int     j, h, k, r;
        bit     found;
        res = '0;
        res.st = STS_OK;
        if (rq == REQ_ALLOC) begin
            found = 0;
            j = o;
            if (o <= z_top) begin
                for (j = o; j <= z_top; j++) begin
                    if (z_head[j] < MAX_FRAMES) begin
                        found = 1;
                        break;
                    end
                end
            end
            if (!found) begin
                res.st = STS_NOFREE;
            end else begin
                h = z_head[j];
                list_cut(h, j);
                z_busy[h] = 1;
                for (k = j; k > o; k--) begin
                    r = halve(h, k);
                    z_busy[r] = 0;
                    list_put(r, k - 1);
                end
                z_ord[h] = 4'(o);
                z_inner[h] = 0;
                res.blk = 12'(h);
                z_free = sub_sat(z_free, 1 << o);
                z_used = add_sat(z_used, 1 << o);
            end
        end else if (ix >= z_count) begin
            res.st = STS_RANGE;
        end else if (rq == REQ_FREE || rq == REQ_RELEASE) begin
            if (!z_busy[ix] || z_inner[ix]) begin
                res.st = STS_STATE;
            end else begin
                k = z_ord[ix];
                z_busy[ix] = 0;
                merge_up(ix);
                if (rq == REQ_FREE && k <= z_top) begin
                    z_free = add_sat(z_free, 1 << k);
                    z_used = sub_sat(z_used, 1 << k);
                end
            end
        end else begin
            found = 0;
            h = 0;
            for (j = ix; j >= 0; j--) begin
                if (!z_inner[j]) begin
                    h = j;
                    found = 1;
                    break;
                end
            end
            if (!found || z_busy[h] || z_ord[h] > z_top || h + (1 << z_ord[h]) <= ix) begin
                res.st = STS_STATE;
            end else begin
                list_cut(h, z_ord[h]);
                while (z_ord[h] > 0) begin
                    k = z_ord[h];
                    r = halve(h, k);
                    if (ix >= r) begin
                        j = h;
                        h = r;
                        r = j;
                    end
                    z_busy[r] = 0;
                    list_put(r, k - 1);
                end
                z_busy[h] = 1;
                z_inner[h] = 0;
                z_free = sub_sat(z_free, 1);
            end
        end
        res.fr = CNT_W'(z_free);
        res.bz = CNT_W'(z_used);
        return res;
    endfunction

    // Presents one request and waits for it to be taken. Called just after a rising edge.
    task automatic send_request(input req_t rq, input int o, input int ix,
                                input bit typed, input reply_t typed_reply,
                                output reply_t predicted);
        if ($urandom_range(99) < sender_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq;
        s_tdata  <= {12'(ix), 4'(o)};
        do @(posedge aclk); while (!s_tready);
        predicted = allocator_step(rq, o, ix);
        awaited_replies.push_back(typed ? typed_reply : predicted);
        requests_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited_replies.size() != 0);
    endtask

    task automatic write_frame_count(input int value);
        drain();
        repeat (SETTLE) @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= '0;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        zone_build(value & 32'h1FFF);
        settings_used++;
    endtask

    // Issues a request and keeps the list of blocks that may be handed back.
    task automatic issue(input req_t rq, input int o, input int ix);
        reply_t p;
        send_request(rq, o, ix, 1'b0, '0, p);
        if (p.st == STS_OK) begin
            if (rq == REQ_ALLOC) held_blocks.push_back(int'(p.blk));
            else if (rq == REQ_RESERVE) held_blocks.push_back(ix);
        end
    endtask

    task automatic run_setting(input int value, input int ops);
        int n, order_set[MAX_FRAMES], j, t, pick, dice;
        write_frame_count(value);
        held_blocks.delete();
        // Initialisation: release frames in a shuffled order so merges happen at random.
        n = (z_count > 128) ? 128 : z_count;
        for (int i = 0; i < n; i++) order_set[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = order_set[i];
            order_set[i] = order_set[j];
            order_set[j] = t;
        end
        for (int i = 0; i < n; i++) issue(REQ_RELEASE, 0, order_set[i]);
        for (int i = 0; i < ops; i++) begin
            dice = $urandom_range(99);
            if (dice < 35) begin
                if ($urandom_range(9) == 0) issue(REQ_ALLOC, $urandom_range(15), 0);
                else issue(REQ_ALLOC, $urandom_range(z_top + 1), $urandom_range(4095));
            end else if (dice < 65) begin
                if (held_blocks.size() != 0) begin
                    pick = $urandom_range(held_blocks.size() - 1);
                    issue(REQ_FREE, $urandom_range(15), held_blocks[pick]);
                    held_blocks.delete(pick);
                end else begin
                    issue(REQ_FREE, 0, $urandom_range(z_count - 1));
                end
            end else if (dice < 77) begin
                issue(REQ_RESERVE, $urandom_range(15), $urandom_range(z_count - 1));
            end else if (dice < 90) begin
                issue(req_t'($urandom_range(3)), $urandom_range(15), $urandom_range(4095));
            end else begin
                issue(REQ_RELEASE, 0, $urandom_range(z_count - 1));
            end
            if ($urandom_range(99) == 0) drain();
        end
    endtask

    step_t steps[$] = '{
        '{0, REQ_ALLOC,   0,  0,    1, STS_NOFREE, 0, 4096, 0},
        '{0, REQ_ALLOC,   12, 0,    1, STS_NOFREE, 0, 4096, 0},
        '{0, REQ_ALLOC,   15, 4095, 1, STS_NOFREE, 0, 4096, 0},
        '{0, REQ_RESERVE, 0,  0,    1, STS_STATE,  0, 4096, 0},
        '{0, REQ_RESERVE, 15, 4095, 1, STS_STATE,  0, 4096, 0},
        '{0, REQ_RELEASE, 0,  0,    1, STS_OK,     0, 4096, 0},
        '{0, REQ_RELEASE, 0,  0,    1, STS_STATE,  0, 4096, 0},
        '{0, REQ_RELEASE, 0,  1,    0, STS_OK,     0, 0,    0},
        '{0, REQ_RELEASE, 0,  2,    0, STS_OK,     0, 0,    0},
        '{0, REQ_RELEASE, 0,  3,    0, STS_OK,     0, 0,    0},
        '{0, REQ_ALLOC,   0,  0,    0, STS_OK,     0, 0,    0},
        '{0, REQ_ALLOC,   1,  0,    0, STS_OK,     0, 0,    0},
        '{0, REQ_FREE,    0,  4095, 0, STS_OK,     0, 0,    0},
        '{0, REQ_FREE,    0,  0,    0, STS_OK,     0, 0,    0},
        '{0, REQ_RESERVE, 0,  2,    0, STS_OK,     0, 0,    0},
        '{0, REQ_RESERVE, 0,  1,    0, STS_OK,     0, 0,    0},
        '{0, REQ_FREE,    0,  1,    0, STS_OK,     0, 0,    0},
        '{0, REQ_ALLOC,   12, 0,    0, STS_OK,     0, 0,    0},
        '{1, REQ_ALLOC,   0,  5,    0, STS_OK,     0, 0,    0},
        '{0, REQ_FREE,    0,  4095, 1, STS_RANGE,  0, 5,    0},
        '{0, REQ_RELEASE, 0,  5,    1, STS_RANGE,  0, 5,    0},
        '{0, REQ_RESERVE, 0,  4095, 1, STS_RANGE,  0, 5,    0},
        '{0, REQ_RELEASE, 0,  4,    0, STS_OK,     0, 0,    0},
        '{0, REQ_ALLOC,   0,  0,    0, STS_OK,     0, 0,    0}
    };

    // Result side: check each accepted reply and pick the next stall.
    always @(posedge aclk) begin
        reply_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[39:0] >> 0;
            got.st  = status_t'(m_tdata[1:0]);
            got.blk = m_tdata[13:2];
            got.fr  = m_tdata[26:14];
            got.bz  = m_tdata[39:27];
            replies_seen++;
            if (awaited_replies.size() == 0) begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10)
                    $display("reply with no request outstanding: %p", got);
            end else begin
                want = awaited_replies.pop_front();
                if (got.st !== want.st || got.blk !== want.blk ||
                    got.fr !== want.fr || got.bz !== want.bz) begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"reply mismatch: expected %s blk %0d free %0d busy %0d,",
                                  " got %s blk %0d free %0d busy %0d"},
                                 want.st.name(), want.blk, want.fr, want.bz,
                                 got.st.name(), got.blk, got.fr, got.bz);
                end
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= receiver_idle);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        reply_t typed_reply, p;
        quiet_cycles = 0;
        sender_idle = 32;
        receiver_idle = 61;
        zone_build(MAX_FRAMES);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (steps[i]) begin
            if (steps[i].cfg) begin
                write_frame_count(steps[i].ix);
            end else begin
                typed_reply.st  = steps[i].st;
                typed_reply.blk = 12'(steps[i].blk);
                typed_reply.fr  = CNT_W'(steps[i].fr);
                typed_reply.bz  = CNT_W'(steps[i].bz);
                send_request(steps[i].rq, steps[i].o, steps[i].ix, steps[i].typed,
                             typed_reply, p);
            end
        end
        run_setting(64, 120);
        run_setting(8191, 120);
        sender_idle = 61;
        receiver_idle = 32;
        run_setting(37, 120);
        run_setting(0, 120);
        sender_idle = 0;
        receiver_idle = 0;
        run_setting(100, 120);
        run_setting(16, 120);
        drain();
        repeat (SETTLE) @(posedge aclk);
        $display("%0d requests over %0d zone sizes (1 to 4096 frames), %0d replies checked,",
                 requests_sent, settings_used + 1, replies_seen);
        $display("%0d mismatches.", mismatches);
        if (!failed && awaited_replies.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
